>>> rtl/core/rtkn_pkg.sv
// Shared types and constants for the rectangle-filtered top-K selector.
package rtkn_pkg;

	localparam int COORD_W = 16;
	localparam int SIZE_W  = 12;
	localparam int DIST_W  = 16;
	localparam int SEL_W   = 5;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_BOTTOM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_TOP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_COUNT = 3'd4;

	localparam logic [SEL_W-1:0] SELECT_COUNT_RST = 5'd2;

	// command codes
	localparam logic CMD_OFFER  = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// link between neighboring cells
	typedef struct packed {
		logic vld;   // cell holds an entry
		logic lt;    // incoming word orders before this cell's entry (or cell empty)
	} rtkn_link_t;

	// per-cycle command to every cell of the chain
	typedef struct packed {
		logic ins;   // insert the stage-1 word
		logic grow;  // insertion extends the list by one
		logic shift; // move every entry one cell toward the head
	} rtkn_ctl_t;

	// stage-1 control
	typedef struct packed {
		logic vld;
		logic fin;
		logic qual;
	} rtkn_s1_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} rtkn_state_t;

endpackage

>>> rtl/core/rtkn_filter.sv
// Stage 1: rectangle overlap test and x distance of an incoming word.
module rtkn_filter import rtkn_pkg::*; #(
	parameter int IDX_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic                       command,
	input  logic [IDX_BITS-1:0]        entity_index,
	input  logic signed [COORD_W-1:0]  entity_x,
	input  logic signed [COORD_W-1:0]  entity_y,
	input  logic [SIZE_W-1:0]          entity_width,
	input  logic [SIZE_W-1:0]          entity_height,
	input  logic                       entity_dead,
	input  logic signed [COORD_W-1:0]  q_left,
	input  logic signed [COORD_W-1:0]  q_bottom,
	input  logic signed [COORD_W-1:0]  q_right,
	input  logic signed [COORD_W-1:0]  q_top,
	output rtkn_s1_t                   ctl_s1,
	output logic [DIST_W-1:0]          dist_s1,
	output logic [IDX_BITS-1:0]        idx_s1
);

	logic signed [COORD_W:0] ex, ey, ex_hi, ey_hi, ql, qb, qr, qt, diff, mag;
	logic qual;

	always_comb begin
		ex    = 17'(signed'(entity_x));
		ey    = 17'(signed'(entity_y));
		ex_hi = ex + signed'({5'b0, entity_width});
		ey_hi = ey + signed'({5'b0, entity_height});
		ql    = 17'(signed'(q_left));
		qb    = 17'(signed'(q_bottom));
		qr    = 17'(signed'(q_right));
		qt    = 17'(signed'(q_top));
		qual  = !entity_dead && (qr >= ex) && (ql <= ex_hi) && (qt >= ey) && (qb <= ey_hi);
		diff  = ex - ql;
		mag   = diff[COORD_W] ? -diff : diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld  <= take;
			ctl_s1.fin  <= (command == CMD_FINISH);
			ctl_s1.qual <= qual;
		end
	end

	// |diff| < 65536 always, so the low bits are exact
	always_ff @(posedge clk) begin
		if (take) begin
			dist_s1 <= mag[DIST_W-1:0];
			idx_s1  <= entity_index;
		end
	end

endmodule

>>> rtl/core/rtkn_cell.sv
// One cell of the sorted insertion chain: holds one kept (distance, index) entry.
module rtkn_cell import rtkn_pkg::*; #(
	parameter int IDX_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rtkn_ctl_t            ctl,
	input  logic [DIST_W-1:0]    new_dist,
	input  logic [IDX_BITS-1:0]  new_idx,
	input  rtkn_link_t           prev_link,
	input  logic [DIST_W-1:0]    prev_dist,
	input  logic [IDX_BITS-1:0]  prev_idx,
	input  logic                 next_vld,
	input  logic [DIST_W-1:0]    next_dist,
	input  logic [IDX_BITS-1:0]  next_idx,
	output rtkn_link_t           link,
	output logic [DIST_W-1:0]    dist_q,
	output logic [IDX_BITS-1:0]  idx_q,
	output logic                 repl
);

	logic vld_q;

	always_comb begin
		link.vld = vld_q;
		link.lt  = !vld_q || (new_dist < dist_q) ||
			((new_dist == dist_q) && (new_idx < idx_q));
		// last kept entry, and the new word is strictly nearer
		repl     = vld_q && !next_vld && (new_dist < dist_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= next_vld;
		end else if (ctl.ins && ctl.grow && prev_link.vld) begin
			vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			dist_q <= next_dist;
			idx_q  <= next_idx;
		end else if (ctl.ins && link.lt) begin
			if (prev_link.lt) begin
				dist_q <= prev_dist;
				idx_q  <= prev_idx;
			end else begin
				dist_q <= new_dist;
				idx_q  <= new_idx;
			end
		end
	end

endmodule

>>> rtl/core/rect_filtered_top_k_nearest.sv
// Top level: rectangle-filtered top-K nearest selector built on a sorted cell chain.
// Offer word: busy stays low, so words may follow back to back; a qualifying entry that
//   is kept lands in the chain at the edge after the accept edge.
// Finish word with n kept: it is registered in stage 1, the FSM enters ST_EMIT, then
//   one result per cycle, n in all; nothing kept: a single found=0 result next cycle.
// Busy falls in the cycle that shows the last result; results cannot be stalled.
// arst_n clears the kept list, the FSM and the result strobe; config registers return to defaults.
module rect_filtered_top_k_nearest import rtkn_pkg::*; #(
	parameter int MAX_SELECT = 16,
	parameter int INDEX_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// command channel
	input  logic                       start,
	output logic                       busy,
	input  logic                       command,
	input  logic [INDEX_BITS-1:0]      entity_index,
	input  logic signed [COORD_W-1:0]  entity_x,
	input  logic signed [COORD_W-1:0]  entity_y,
	input  logic [SIZE_W-1:0]          entity_width,
	input  logic [SIZE_W-1:0]          entity_height,
	input  logic                       entity_dead,
	// configuration write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [COORD_W-1:0]         cfg_data,
	// results
	output logic                       result_valid,
	output logic [INDEX_BITS-1:0]      result_index,
	output logic [DIST_W-1:0]          result_distance,
	output logic                       found,
	output logic                       last_result
);

	localparam int KW = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;
	localparam logic [6:0] MAX_SEL_7 = 7'(MAX_SELECT);

	// ---------------- configuration registers ----------------
	logic signed [COORD_W-1:0] q_left_q, q_bottom_q, q_right_q, q_top_q;
	logic [SEL_W-1:0]          sel_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_left_q   <= '0;
			q_bottom_q <= '0;
			q_right_q  <= '0;
			q_top_q    <= '0;
			sel_q      <= SELECT_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_QUERY_LEFT:   q_left_q   <= cfg_data;
				REG_QUERY_BOTTOM: q_bottom_q <= cfg_data;
				REG_QUERY_RIGHT:  q_right_q  <= cfg_data;
				REG_QUERY_TOP:    q_top_q    <= cfg_data;
				REG_SELECT_COUNT: sel_q      <= cfg_data[SEL_W-1:0];
				default: ; // writes past the register list are dropped
			endcase
		end
	end

	// ---------------- stage 1: filter and distance ----------------
	rtkn_s1_t               ctl_s1;
	logic [DIST_W-1:0]      dist_s1;
	logic [INDEX_BITS-1:0]  idx_s1;
	logic                   take;
	rtkn_state_t            state_q;

	// a finish word sitting in stage 1 already blocks the next word
	assign busy = (state_q == ST_EMIT) || (ctl_s1.vld && ctl_s1.fin);
	assign take = start && !busy;

	rtkn_filter #(.IDX_BITS(INDEX_BITS)) u_filter (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.command      (command),
		.entity_index (entity_index),
		.entity_x     (entity_x),
		.entity_y     (entity_y),
		.entity_width (entity_width),
		.entity_height(entity_height),
		.entity_dead  (entity_dead),
		.q_left       (q_left_q),
		.q_bottom     (q_bottom_q),
		.q_right      (q_right_q),
		.q_top        (q_top_q),
		.ctl_s1       (ctl_s1),
		.dist_s1      (dist_s1),
		.idx_s1       (idx_s1)
	);

	// ---------------- the cell chain ----------------
	// Slot 0 is the head stub, slot i+1 is cell i, slot MAX_SELECT+1 the tail stub.
	rtkn_link_t            lk   [MAX_SELECT+2];
	logic [DIST_W-1:0]     dst  [MAX_SELECT+2];
	logic [INDEX_BITS-1:0] idx  [MAX_SELECT+2];
	logic [MAX_SELECT-1:0] vld_vec, repl_vec;
	rtkn_ctl_t             ctl;
	logic                  full, ins_ok;
	logic [KW-1:0]         kidx;

	assign lk[0]             = '{vld: 1'b1, lt: 1'b0};
	assign dst[0]            = '0;
	assign idx[0]            = '0;
	assign lk[MAX_SELECT+1]  = '{vld: 1'b0, lt: 1'b1};
	assign dst[MAX_SELECT+1] = '0;
	assign idx[MAX_SELECT+1] = '0;

	for (genvar i = 0; i < MAX_SELECT; i++) begin : g_cell
		rtkn_cell #(.IDX_BITS(INDEX_BITS)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_dist  (dist_s1),
			.new_idx   (idx_s1),
			.prev_link (lk[i]),
			.prev_dist (dst[i]),
			.prev_idx  (idx[i]),
			.next_vld  (lk[i+2].vld),
			.next_dist (dst[i+2]),
			.next_idx  (idx[i+2]),
			.link      (lk[i+1]),
			.dist_q    (dst[i+1]),
			.idx_q     (idx[i+1]),
			.repl      (repl_vec[i])
		);
		assign vld_vec[i] = lk[i+1].vld;
	end

	// K-1, with K=0 read as 1 and K above the chain length clamped
	always_comb begin
		if (sel_q == '0) begin
			kidx = '0;
		end else if ({2'b00, sel_q} > MAX_SEL_7) begin
			kidx = KW'(MAX_SELECT - 1);
		end else begin
			kidx = KW'(sel_q - 5'd1);
		end
	end

	// entries form a prefix, so "count >= K" is just "cell K-1 holds one"
	assign full   = vld_vec[kidx];
	assign ins_ok = !full || (|repl_vec);

	always_comb begin
		ctl.ins   = ctl_s1.vld && !ctl_s1.fin && ctl_s1.qual && ins_ok;
		ctl.grow  = !full;   // on replacement the old tail falls off the end
		ctl.shift = (state_q == ST_EMIT);
	end

	// ---------------- emit sequencer and result register ----------------
	logic                  res_vld_q, found_q, last_q;
	logic [INDEX_BITS-1:0] res_idx_q;
	logic [DIST_W-1:0]     res_dist_q;
	logic                  head_last;

	// head entry is the final one when cell 1 is empty (or there is no cell 1)
	assign head_last = !lk[2].vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (ctl_s1.vld && ctl_s1.fin) begin
						if (vld_vec[0]) begin
							state_q <= ST_EMIT;
						end else begin
							res_vld_q <= 1'b1; // empty query: single not-found word
						end
					end
				end
				ST_EMIT: begin
					res_vld_q <= 1'b1;
					if (head_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			res_idx_q  <= idx[1];
			res_dist_q <= dst[1];
			found_q    <= 1'b1;
			last_q     <= head_last;
		end else begin
			res_idx_q  <= '0;
			res_dist_q <= '0;
			found_q    <= 1'b0;
			last_q     <= 1'b1;
		end
	end

	assign result_valid    = res_vld_q;
	assign result_index    = res_idx_q;
	assign result_distance = res_dist_q;
	assign found           = found_q;
	assign last_result     = last_q;

	// ---------------- assertions ----------------
	a_emit_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> vld_vec[0])
		else $error("emit pass with empty head cell");

	a_emit_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |=> res_vld_q)
		else $error("emit cycle produced no result");

	a_notfound_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && !found_q) |-> last_q)
		else $error("not-found result not marked last");

	a_no_ins_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |-> (state_q == ST_IDLE))
		else $error("insertion during emit pass");

endmodule
